[rtl/core/media_type_header_parser_unit_defines.svh]
// assertion macros used by the media-type header parser rtl
`ifndef MEDIA_TYPE_HEADER_PARSER_UNIT_DEFINES_SVH
`define MEDIA_TYPE_HEADER_PARSER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MTHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MTHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mthp_pkg.sv]
// shared types, character codes and helper functions of the media-type header parser
package mthp_pkg;

  // default queue depths (power of two, at least two)
  localparam int unsigned MidDepthDef = 2;
  localparam int unsigned OutDepthDef = 2;

  // character codes with a grammar role of their own
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  // role tag of a result byte
  typedef enum logic [2:0] {
    ROLE_SKIP  = 3'd0,
    ROLE_TYPE  = 3'd1,
    ROLE_SLASH = 3'd2,
    ROLE_SUB   = 3'd3,
    ROLE_KEY   = 3'd4,
    ROLE_VAL   = 3'd5,
    ROLE_QUOTE = 3'd6
  } role_e;

  // parse states, one-hot
  typedef enum logic [11:0] {
    ST_LEAD    = 12'b0000_0000_0001,
    ST_TYPE0   = 12'b0000_0000_0010,
    ST_TYPE    = 12'b0000_0000_0100,
    ST_SUB0    = 12'b0000_0000_1000,
    ST_SUB     = 12'b0000_0001_0000,
    ST_OWS     = 12'b0000_0010_0000,
    ST_SEMI    = 12'b0000_0100_0000,
    ST_KEY     = 12'b0000_1000_0000,
    ST_VAL0    = 12'b0001_0000_0000,
    ST_TOKVAL  = 12'b0010_0000_0000,
    ST_QVAL    = 12'b0100_0000_0000,
    ST_QPAIR   = 12'b1000_0000_0000
  } state_e;

  // character class flags decoded by the front end
  typedef struct packed {
    logic ws;
    logic tok;
    logic slash;
    logic semi;
    logic eq;
    logic dquote;
    logic bslash;
  } cls_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    cls_t       cls;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] char_out;
    logic [7:0] lower_out;
    role_e      role;
    logic       param_done;
    logic       parse_error;
    logic       done_res;
    logic       accepted;
  } res_t;

  // white space: tab through carriage return, and space
  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // token characters
  function automatic logic is_tok(logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      [8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
      8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // fold upper case to lower case
  function automatic logic [7:0] fold(logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CASE_OFS) : c;
  endfunction

endpackage

[rtl/core/mthp_fifo.sv]
// small synchronous queue with full and empty flags
module mthp_fifo import mthp_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = MidDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  // handshake qualification
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i & ~full_o;
  assign do_rd   = rd_en_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wptr_d = do_wr ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_rd ? rptr_q + 1'b1 : rptr_q;
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rptr_q];

endmodule

[rtl/core/mthp_front.sv]
// front end: byte intake and character class decode
module mthp_front import mthp_pkg::*; (
  input  logic       push_i,
  input  logic [7:0] char_in_i,
  input  logic       last_i,
  input  logic       mid_full_i,
  output logic       full_o,
  output logic       mid_push_o,
  output item_t      item_o
);

  // input side mirrors the queue between front and back
  assign full_o     = mid_full_i;
  assign mid_push_o = push_i;

  // character class decode of the incoming byte
  always_comb begin
    item_o.ch         = char_in_i;
    item_o.last       = last_i;
    item_o.cls.ws     = is_ws(char_in_i);
    item_o.cls.tok    = is_tok(char_in_i);
    item_o.cls.slash  = (char_in_i == CH_SLASH);
    item_o.cls.semi   = (char_in_i == CH_SEMI);
    item_o.cls.eq     = (char_in_i == CH_EQ);
    item_o.cls.dquote = (char_in_i == CH_DQUOTE);
    item_o.cls.bslash = (char_in_i == CH_BSLASH);
  end

endmodule

[rtl/core/mthp_back.sv]
// back end: media-type grammar state machine producing one result per byte
module mthp_back import mthp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  item_take_o,
  input  logic  res_full_i,
  output logic  res_push_o,
  output res_t  res_o
);

`include "media_type_header_parser_unit_defines.svh"

  state_e st_q, st_d, eff, nst, st_keep;
  logic   err_q, err_d, err_new;
  logic   bad, pdone, valid_end, proc;
  role_e  role;

  // a byte is carried out when one waits and the result queue has room
  assign proc        = item_valid_i & ~res_full_i;
  assign item_take_o = proc;
  assign res_push_o  = proc;

  // grammar step
  always_comb begin
    eff   = st_q;
    nst   = st_q;
    role  = ROLE_SKIP;
    pdone = 1'b0;
    bad   = 1'b0;
    if (!err_q) begin
      if ((st_q == ST_LEAD) && !item_i.cls.ws) begin
        eff = ST_TYPE0;
      end
      nst = eff;
      case (eff)
        ST_LEAD: begin
          nst = ST_LEAD;
        end
        ST_TYPE0: begin
          if (item_i.cls.tok) begin
            role = ROLE_TYPE;
            nst  = ST_TYPE;
          end else begin
            bad = 1'b1;
          end
        end
        ST_TYPE: begin
          if (item_i.cls.tok) begin
            role = ROLE_TYPE;
          end else if (item_i.cls.slash) begin
            role = ROLE_SLASH;
            nst  = ST_SUB0;
          end else begin
            bad = 1'b1;
          end
        end
        ST_SUB0: begin
          if (item_i.cls.tok) begin
            role = ROLE_SUB;
            nst  = ST_SUB;
          end else begin
            bad = 1'b1;
          end
        end
        ST_SUB: begin
          if (item_i.cls.tok) begin
            role = ROLE_SUB;
          end else if (item_i.cls.semi) begin
            nst = ST_SEMI;
          end else if (item_i.cls.ws) begin
            nst = ST_OWS;
          end else begin
            bad = 1'b1;
          end
        end
        ST_OWS: begin
          if (item_i.cls.semi) begin
            nst = ST_SEMI;
          end else if (!item_i.cls.ws) begin
            bad = 1'b1;
          end
        end
        ST_SEMI: begin
          if (item_i.cls.tok) begin
            role = ROLE_KEY;
            nst  = ST_KEY;
          end else if (!item_i.cls.semi && !item_i.cls.ws) begin
            bad = 1'b1;
          end
        end
        ST_KEY: begin
          if (item_i.cls.tok) begin
            role = ROLE_KEY;
          end else if (item_i.cls.eq) begin
            nst = ST_VAL0;
          end else begin
            bad = 1'b1;
          end
        end
        ST_VAL0: begin
          if (item_i.cls.dquote) begin
            role = ROLE_QUOTE;
            nst  = ST_QVAL;
          end else if (item_i.cls.tok) begin
            role = ROLE_VAL;
            nst  = ST_TOKVAL;
          end else begin
            bad = 1'b1;
          end
        end
        ST_TOKVAL: begin
          if (item_i.cls.tok) begin
            role = ROLE_VAL;
          end else if (item_i.cls.semi) begin
            pdone = 1'b1;
            nst   = ST_SEMI;
          end else if (item_i.cls.ws) begin
            pdone = 1'b1;
            nst   = ST_OWS;
          end else begin
            bad = 1'b1;
          end
        end
        ST_QVAL: begin
          if (item_i.cls.dquote) begin
            role  = ROLE_QUOTE;
            pdone = 1'b1;
            nst   = ST_OWS;
          end else if (item_i.cls.bslash) begin
            role = ROLE_QUOTE;
            nst  = ST_QPAIR;
          end else begin
            role = ROLE_VAL;
          end
        end
        ST_QPAIR: begin
          role = ROLE_VAL;
          nst  = ST_QVAL;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end

    // error freezes the state and blanks the tags
    err_new = err_q | bad;
    st_keep = bad ? st_q : nst;
    if (bad) begin
      role  = ROLE_SKIP;
      pdone = 1'b0;
    end else if (!err_q && item_i.last && (nst == ST_TOKVAL)) begin
      pdone = 1'b1;
    end

    valid_end = !err_new && ((st_keep == ST_SUB) || (st_keep == ST_OWS) ||
                             (st_keep == ST_SEMI) || (st_keep == ST_TOKVAL));
  end

  // result assembly
  always_comb begin
    res_o.char_out    = item_i.ch;
    res_o.lower_out   = ((role == ROLE_TYPE) || (role == ROLE_SUB)) ? fold(item_i.ch)
                                                                    : item_i.ch;
    res_o.role        = role;
    res_o.param_done  = pdone;
    res_o.parse_error = err_new;
    res_o.done_res    = item_i.last;
    res_o.accepted    = item_i.last & valid_end;
  end

  // state update, cleared after the last byte of a value
  always_comb begin
    st_d  = st_q;
    err_d = err_q;
    if (proc) begin
      if (item_i.last) begin
        st_d  = ST_LEAD;
        err_d = 1'b0;
      end else begin
        st_d  = st_keep;
        err_d = err_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_LEAD;
      err_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      err_q <= err_d;
    end
  end

  // checks
  `MTHP_ASSERT_NEXT(a_last_clears, proc && item_i.last, (st_q == ST_LEAD) && !err_q, "state not cleared after last byte")
  `MTHP_ASSERT_NOW(a_err_blanks, proc && err_q, res_o.parse_error && (res_o.role == ROLE_SKIP) && !res_o.param_done, "byte after error not blanked")
  `MTHP_ASSERT_NOW(a_accept_clean, proc && res_o.accepted, res_o.done_res && !res_o.parse_error, "accepted without clean last byte")
  `MTHP_ASSERT_NEXT(a_err_sticky, proc && err_new && !item_i.last, err_q, "error flag dropped inside a value")

endmodule

[rtl/core/media_type_header_parser_unit.sv]
// top level of the media-type header parser: front end, queues and grammar back end
// Takes one Content-Type header byte per cycle (push/full) and returns one result
// per byte (empty/pop), in order. A byte taken by a push is decoded into its
// character class, registered in a small queue, and carried out by the grammar
// state machine once the result queue has room; its result is then registered in
// the result queue for pop. Sustained rate is one byte per cycle while neither
// side stalls; the queues (MidDepth and OutDepth entries) absorb either stall.
module media_type_header_parser_unit import mthp_pkg::*; #(
  parameter int unsigned MidDepth = MidDepthDef,
  parameter int unsigned OutDepth = OutDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out_o,
  output logic [7:0] lower_out_o,
  output logic [2:0] role_o,
  output logic       param_done_o,
  output logic       parse_error_o,
  output logic       done_res_o,
  output logic       accepted_o
);

  localparam int unsigned ItemW = $bits(item_t);
  localparam int unsigned ResW  = $bits(res_t);

  logic             mid_push, mid_full, mid_empty, mid_take;
  item_t            front_item;
  logic [ItemW-1:0] mid_rd;
  item_t            back_item;
  logic             res_push, res_full;
  res_t             back_res, out_res;
  logic [ResW-1:0]  out_rd;

  // front end
  mthp_front u_front (
    .push_i     (push),
    .char_in_i  (char_in_i),
    .last_i     (end_of_text_i),
    .mid_full_i (mid_full),
    .full_o     (full),
    .mid_push_o (mid_push),
    .item_o     (front_item)
  );

  // queue between front and back
  mthp_fifo #(
    .WIDTH (ItemW),
    .DEPTH (MidDepth)
  ) u_mid_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mid_push),
    .wr_data_i (front_item),
    .full_o    (mid_full),
    .rd_en_i   (mid_take),
    .rd_data_o (mid_rd),
    .empty_o   (mid_empty)
  );

  assign back_item = item_t'(mid_rd);

  // grammar back end
  mthp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~mid_empty),
    .item_i       (back_item),
    .item_take_o  (mid_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  // result queue
  mthp_fifo #(
    .WIDTH (ResW),
    .DEPTH (OutDepth)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (back_res),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (out_rd),
    .empty_o   (empty)
  );

  // result ports
  assign out_res       = res_t'(out_rd);
  assign char_out_o    = out_res.char_out;
  assign lower_out_o   = out_res.lower_out;
  assign role_o        = out_res.role;
  assign param_done_o  = out_res.param_done;
  assign parse_error_o = out_res.parse_error;
  assign done_res_o    = out_res.done_res;
  assign accepted_o    = out_res.accepted;

endmodule
